### rtl/lrtc_pkg.sv
// Package for the left-to-right token calculator.
// Holds value width, character codes, operator and scan codes and shared types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lrtc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CHAR_W      = 8;
    localparam int LINE_W      = 32;
    localparam int COUNT_W     = $clog2(VALUE_WIDTH);

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_ANY       = 3'd0,
        PH_OPCHAR    = 3'd1,
        PH_NEED_NUM  = 3'd2,
        PH_NUM_NEW   = 3'd3,
        PH_NUM_OPND  = 3'd4,
        PH_TAIL_NEW  = 3'd5,
        PH_TAIL_OPND = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CALC = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_ctrl_t;

endpackage

`default_nettype wire

### rtl/lrtc_muldiv.sv
// Iterative multiply and signed divide unit of the token calculator.
// One shared adder/subtractor does one shift-add or restoring step per cycle.
// Depends on lrtc_pkg.
`default_nettype none

module lrtc_muldiv (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  lrtc_pkg::md_ctrl_t                  md_ctrl,
    input  wire  [lrtc_pkg::VALUE_WIDTH-1:0]    op_a,
    input  wire  [lrtc_pkg::VALUE_WIDTH-1:0]    op_b,
    output logic                                done,
    output logic [lrtc_pkg::VALUE_WIDTH-1:0]    result
);
    import lrtc_pkg::*;

    logic [VALUE_WIDTH-1:0] x_reg, x_next;
    logic [VALUE_WIDTH-1:0] y_reg, y_next;
    logic [VALUE_WIDTH-1:0] z_reg, z_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   div_reg, div_next;
    logic                   neg_reg, neg_next;

    logic [VALUE_WIDTH-1:0] mag_a, mag_b;
    logic [VALUE_WIDTH:0]   opx, opy;
    logic                   sub;
    logic [VALUE_WIDTH+1:0] sum;
    logic                   no_borrow;

    always_comb begin
        mag_a = op_a[VALUE_WIDTH-1] ? (~op_a + VALUE_WIDTH'(1)) : op_a;
        mag_b = op_b[VALUE_WIDTH-1] ? (~op_b + VALUE_WIDTH'(1)) : op_b;

        if (div_reg) begin
            opx = {x_reg, z_reg[VALUE_WIDTH-1]};
            sub = 1'b1;
        end else begin
            opx = {1'b0, x_reg};
            sub = 1'b0;
        end
        opy = {1'b0, y_reg};
        sum = {1'b0, opx} + {1'b0, (sub ? ~opy : opy)} + (VALUE_WIDTH+2)'(sub);
        no_borrow = sum[VALUE_WIDTH+1];

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;

        if (md_ctrl.start) begin
            x_next    = '0;
            div_next  = md_ctrl.is_div;
            neg_next  = op_a[VALUE_WIDTH-1] ^ op_b[VALUE_WIDTH-1];
            y_next    = md_ctrl.is_div ? mag_b : op_b;
            z_next    = md_ctrl.is_div ? mag_a : op_a;
            cnt_next  = COUNT_W'(VALUE_WIDTH-1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (div_reg) begin
                x_next = no_borrow ? sum[VALUE_WIDTH-1:0] : opx[VALUE_WIDTH-1:0];
                z_next = {z_reg[VALUE_WIDTH-2:0], no_borrow};
            end else begin
                x_next = z_reg[0] ? sum[VALUE_WIDTH-1:0] : x_reg;
                y_next = {y_reg[VALUE_WIDTH-2:0], 1'b0};
                z_next = {1'b0, z_reg[VALUE_WIDTH-1:1]};
            end
            cnt_next = cnt_reg - COUNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
            neg_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
            neg_reg  <= neg_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (~z_reg + VALUE_WIDTH'(1)) : z_reg) : x_reg;

endmodule

`default_nettype wire

### rtl/left_to_right_token_calculator.sv
// Top level of the left-to-right token calculator: scanner, accumulator and result register.
// Instantiates lrtc_muldiv for multiply and divide operands; depends on lrtc_pkg.
//
// Usage: one character byte per request on s_tdata. Space and tab separate tokens;
// a newline closes the line and produces one request on the m_ side, with the line's
// value on m_tdata and the well-formed flag on m_tuser. Operators apply left to right
// with no precedence, and values wrap at the value width.
// Flow: ordinary characters are accepted back to back while the block is idle. A
// separator or newline that closes the operand of * or / (divisor nonzero, line
// not in error) holds s_tready low while the one-bit-per-cycle multiply/divide
// unit works. After a newline the block enters the emit state, which loads the
// output register before the block returns to idle.
// Stall: the output register holds its result while m_tready is low. Characters
// keep being accepted; a further newline is taken and then holds s_tready low until
// the register is free.
// Reset: aresetn clears the accumulator, scan state and output valid; the block is
// ready as soon as reset is released.
`default_nettype none

module left_to_right_token_calculator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] char_code
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [31:0] line_value
    output logic [0:0]  m_tuser     // [0] line_ok
);
    import lrtc_pkg::*;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    op_t                    op_reg, op_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] lit_reg, lit_next;
    logic                   err_reg, err_next;
    logic                   eol_pend_reg, eol_pend_next;
    logic                   m_valid_reg, m_valid_next;
    logic [LINE_W-1:0]      out_value_reg, out_value_next;
    logic                   out_ok_reg, out_ok_next;

    md_ctrl_t               md_ctrl;
    logic                   md_done;
    logic [VALUE_WIDTH-1:0] md_result;

    logic                   accept, is_sep, is_eol, is_digit, is_op, started;
    op_t                    char_op;
    logic [VALUE_WIDTH-1:0] digit_val;
    logic [VALUE_WIDTH+LINE_W-1:0] acc_ext;

    lrtc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .md_ctrl (md_ctrl),
        .op_a    (acc_reg),
        .op_b    (lit_reg),
        .done    (md_done),
        .result  (md_result)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        is_sep    = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
        is_eol    = (s_tdata == CH_LF);
        is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
        digit_val = {{(VALUE_WIDTH-4){1'b0}}, s_tdata[3:0]};
        is_op     = 1'b1;
        case (s_tdata)
            CH_PLUS:  char_op = OP_ADD;
            CH_MINUS: char_op = OP_SUB;
            CH_STAR:  char_op = OP_MUL;
            CH_SLASH: char_op = OP_DIV;
            default: begin
                char_op = OP_ADD;
                is_op   = 1'b0;
            end
        endcase
        acc_ext = {{LINE_W{acc_reg[VALUE_WIDTH-1]}}, acc_reg};

        state_next     = state_reg;
        phase_next     = phase_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        lit_next       = lit_reg;
        err_next       = err_reg;
        eol_pend_next  = eol_pend_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        md_ctrl.start  = 1'b0;
        md_ctrl.is_div = (op_reg == OP_DIV);
        started        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (is_sep || is_eol)) begin
                    if (!err_reg) begin
                        case (phase_reg)
                            PH_NUM_NEW, PH_TAIL_NEW: begin
                                acc_next   = lit_reg;
                                lit_next   = '0;
                                phase_next = PH_ANY;
                            end
                            PH_NUM_OPND, PH_TAIL_OPND: begin
                                lit_next   = '0;
                                phase_next = PH_ANY;
                                case (op_reg)
                                    OP_ADD: acc_next = acc_reg + lit_reg;
                                    OP_SUB: acc_next = acc_reg - lit_reg;
                                    OP_MUL: started = 1'b1;
                                    default: begin
                                        if (lit_reg == '0) begin
                                            err_next = 1'b1;
                                        end else begin
                                            started = 1'b1;
                                        end
                                    end
                                endcase
                            end
                            PH_OPCHAR: begin
                                phase_next = PH_NEED_NUM;
                                if (is_eol) begin
                                    err_next = 1'b1;
                                end
                            end
                            PH_NEED_NUM: begin
                                if (is_eol) begin
                                    err_next = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    md_ctrl.start = started;
                    eol_pend_next = is_eol;
                    if (started) begin
                        state_next = ST_CALC;
                    end else if (is_eol) begin
                        state_next = ST_EMIT;
                    end
                end else if (accept && !err_reg) begin
                    case (phase_reg)
                        PH_ANY: begin
                            if (is_digit) begin
                                lit_next   = digit_val;
                                phase_next = PH_NUM_NEW;
                            end else if (is_op) begin
                                op_next    = char_op;
                                phase_next = PH_OPCHAR;
                            end else begin
                                err_next = 1'b1;
                            end
                        end
                        PH_NEED_NUM: begin
                            if (is_digit) begin
                                lit_next   = digit_val;
                                phase_next = PH_NUM_OPND;
                            end else begin
                                err_next = 1'b1;
                            end
                        end
                        PH_NUM_NEW, PH_NUM_OPND: begin
                            if (is_digit) begin
                                lit_next = {lit_reg[VALUE_WIDTH-4:0], 3'b000}
                                         + {lit_reg[VALUE_WIDTH-2:0], 1'b0} + digit_val;
                            end else begin
                                phase_next = (phase_reg == PH_NUM_NEW) ? PH_TAIL_NEW
                                                                       : PH_TAIL_OPND;
                            end
                        end
                        PH_TAIL_NEW, PH_TAIL_OPND: ;
                        default: err_next = 1'b1;
                    endcase
                end
            end
            ST_CALC: begin
                if (md_done) begin
                    acc_next   = md_result;
                    state_next = eol_pend_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    out_value_next = err_reg ? '0 : acc_ext[LINE_W-1:0];
                    out_ok_next    = !err_reg;
                    acc_next       = '0;
                    lit_next       = '0;
                    op_next        = OP_ADD;
                    phase_next     = PH_ANY;
                    err_next       = 1'b0;
                    eol_pend_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_ANY;
            op_reg       <= OP_ADD;
            acc_reg      <= '0;
            lit_reg      <= '0;
            err_reg      <= 1'b0;
            eol_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            op_reg       <= op_next;
            acc_reg      <= acc_next;
            lit_reg      <= lit_next;
            err_reg      <= err_next;
            eol_pend_reg <= eol_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_ok_reg;

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> state_reg == ST_CALC)
        else $error("multiply/divide completion outside the calculation state");

    a_start_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        md_ctrl.start |=> ($past(accept && (is_sep || is_eol)) && state_reg == ST_CALC))
        else $error("unit started without a closing separator request");

    a_error_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tdata == '0)
        else $error("malformed line reported a nonzero value");

    a_line_scrubbed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && (!m_valid_reg || m_tready))
        |=> (phase_reg == PH_ANY && !err_reg && acc_reg == '0 && m_valid_reg))
        else $error("line state not cleared after result was issued");

endmodule

`default_nettype wire
